/* rtl/cbr_pkg.sv */
`timescale 1ns / 1ps
package cbr_pkg;

    localparam int COMP_W       = 16;
    localparam int CORDIC_STEPS = 16;

    localparam logic [31:0]        TINY_Q12    = 32'd16;
    localparam logic [31:0]        TINY_Q14    = 32'd268;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef t_comp t_vec [0:2];

    typedef enum logic [2:0] {
        OP_SET_FWD = 3'd0,
        OP_SET_UP  = 3'd1,
        OP_YAW     = 3'd2,
        OP_PITCH   = 3'd3,
        OP_ROLL    = 3'd4
    } t_op;

    typedef enum logic [1:0] {K_END, K_NORM, K_MIX, K_CORDIC} t_kind;
    typedef enum logic [2:0] {V_F, V_U, V_R, V_T, V_X} t_vsel;
    typedef enum logic [2:0] {
        M_CROSS_FU, M_CROSS_RF, M_YAW, M_PITCH_F, M_PITCH_U, M_ROLL
    } t_mix;

    typedef struct packed {
        t_kind kind;
        t_vsel src;
        t_vsel dst;
        logic  fi12;
        t_mix  mix;
    } t_uop;

    typedef struct packed {
        logic load_in;
        logic norm_start;
        logic mix_start;
        logic cordic_start;
        logic out_load;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic norm_done;
        logic mix_done;
        logic cordic_done;
    } t_sts;

    typedef enum logic [1:0] {CS_IDLE, CS_ISSUE, CS_WAIT, CS_OUT} t_cstate;
    typedef enum logic [2:0] {
        NS_IDLE, NS_SQ, NS_CHK, NS_SHIFT, NS_SQRT, NS_DLD, NS_DIV
    } t_nstate;

    function automatic t_comp pick(input t_vec v, input logic [1:0] idx);
        case (idx)
            2'd0:    return v[0];
            2'd1:    return v[1];
            default: return v[2];
        endcase
    endfunction

    function automatic t_comp sat_comp(input logic signed [18:0] v);
        if (v > 19'sd32767)       return 16'sh7FFF;
        else if (v < -19'sd32768) return 16'sh8000;
        else                      return v[15:0];
    endfunction

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  return 30'd843314857;
            5'd1:  return 30'd497837829;
            5'd2:  return 30'd263043837;
            5'd3:  return 30'd133525159;
            5'd4:  return 30'd67021687;
            5'd5:  return 30'd33543516;
            5'd6:  return 30'd16775851;
            5'd7:  return 30'd8388437;
            5'd8:  return 30'd4194283;
            5'd9:  return 30'd2097149;
            5'd10: return 30'd1048576;
            5'd11: return 30'd524288;
            5'd12: return 30'd262144;
            5'd13: return 30'd131072;
            5'd14: return 30'd65536;
            5'd15: return 30'd32768;
            5'd16: return 30'd16384;
            5'd17: return 30'd8192;
            5'd18: return 30'd4096;
            5'd19: return 30'd2048;
            5'd20: return 30'd1024;
            5'd21: return 30'd512;
            5'd22: return 30'd256;
            5'd23: return 30'd128;
            5'd24: return 30'd64;
            5'd25: return 30'd32;
            5'd26: return 30'd16;
            5'd27: return 30'd8;
            5'd28: return 30'd4;
            5'd29: return 30'd2;
            default: return 30'd0;
        endcase
    endfunction

    function automatic t_uop u_end();
        t_uop u;
        u = '{kind: K_END, src: V_X, dst: V_T, fi12: 1'b0, mix: M_CROSS_FU};
        return u;
    endfunction

    function automatic t_uop u_norm(input t_vsel s, input t_vsel d, input logic f12);
        t_uop u;
        u = '{kind: K_NORM, src: s, dst: d, fi12: f12, mix: M_CROSS_FU};
        return u;
    endfunction

    function automatic t_uop u_mix(input t_mix m);
        t_uop u;
        u = '{kind: K_MIX, src: V_X, dst: V_T, fi12: 1'b0, mix: m};
        return u;
    endfunction

    function automatic t_uop u_cor();
        t_uop u;
        u = '{kind: K_CORDIC, src: V_X, dst: V_T, fi12: 1'b0, mix: M_CROSS_FU};
        return u;
    endfunction

    // micro-program: one entry per step of each operation
    function automatic t_uop uop_at(input logic [2:0] op, input logic [2:0] step);
        t_uop u;
        u = u_end();
        case (op)
            OP_SET_FWD, OP_SET_UP: begin
                case (step)
                    3'd0: u = u_norm(V_X, (op == OP_SET_FWD) ? V_F : V_U, 1'b1);
                    3'd1: u = u_norm(V_F, V_F, 1'b0);
                    3'd2: u = u_mix(M_CROSS_FU);
                    3'd3: u = u_norm(V_T, V_R, 1'b0);
                    3'd4: u = u_mix(M_CROSS_RF);
                    3'd5: u = u_norm(V_T, V_U, 1'b0);
                    default: u = u_end();
                endcase
            end
            OP_YAW: begin
                case (step)
                    3'd0: u = u_cor();
                    3'd1: u = u_mix(M_YAW);
                    3'd2: u = u_norm(V_T, V_F, 1'b0);
                    3'd3: u = u_mix(M_CROSS_FU);
                    3'd4: u = u_norm(V_T, V_R, 1'b0);
                    default: u = u_end();
                endcase
            end
            OP_PITCH: begin
                case (step)
                    3'd0: u = u_cor();
                    3'd1: u = u_mix(M_PITCH_F);
                    3'd2: u = u_mix(M_PITCH_U);
                    3'd3: u = u_norm(V_T, V_F, 1'b0);
                    3'd4: u = u_norm(V_X, V_U, 1'b0);
                    3'd5: u = u_mix(M_CROSS_FU);
                    3'd6: u = u_norm(V_T, V_R, 1'b0);
                    default: u = u_end();
                endcase
            end
            OP_ROLL: begin
                case (step)
                    3'd0: u = u_cor();
                    3'd1: u = u_mix(M_ROLL);
                    3'd2: u = u_norm(V_X, V_U, 1'b0);
                    3'd3: u = u_mix(M_CROSS_FU);
                    3'd4: u = u_norm(V_T, V_R, 1'b0);
                    default: u = u_end();
                endcase
            end
            default: u = u_end();
        endcase
        return u;
    endfunction

endpackage

/* rtl/camera_basis_rotator.sv */
`timescale 1ns / 1ps
// Camera basis keeper: holds forward, up and right unit vectors (Q2.14) and applies one
// operation per input beat (tuser: 0 set forward, 1 set up, 2 yaw, 3 pitch, 4 roll; other
// codes just return the basis). Each beat returns the nine basis components after the
// operation. One beat is worked at a time. Most of the time goes to the normalize unit,
// which for a near-zero vector skips its square root and divides, and otherwise runs a
// 32-step square root plus three 16-step divides; set ops run four normalizations and two
// cross products, rotations add a CORDIC ahead of their products and normalizations;
// vectors that are near zero or parallel make the normalizations short. A new beat is
// taken while the previous result still waits.
module camera_basis_rotator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [63:0]   i_s_axis_tdata,  // vec_x, vec_y, vec_z, angle
    input  logic [2:0]    i_s_axis_tuser,  // op
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [143:0]  o_m_axis_tdata   // fwd_x/y/z, up_vec_x/y/z, rgt_x/y/z
);

    cbr_pkg::t_cmd w_cmd;
    cbr_pkg::t_sts w_sts;
    cbr_pkg::t_vec w_vec, w_fwd, w_up, w_rgt;

    assign w_vec[0] = i_s_axis_tdata[15:0];
    assign w_vec[1] = i_s_axis_tdata[31:16];
    assign w_vec[2] = i_s_axis_tdata[47:32];

    cbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_op        (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cbr_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_vec   (w_vec),
        .i_angle (i_s_axis_tdata[63:48]),
        .o_sts   (w_sts),
        .o_fwd   (w_fwd),
        .o_up    (w_up),
        .o_rgt   (w_rgt)
    );

    assign o_m_axis_tdata = {w_rgt[2], w_rgt[1], w_rgt[0],
                             w_up[2],  w_up[1],  w_up[0],
                             w_fwd[2], w_fwd[1], w_fwd[0]};

endmodule

/* rtl/cbr_norm.sv */
`timescale 1ns / 1ps
module cbr_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_fi12,
    input  cbr_pkg::t_vec i_vec,
    output logic          o_done,
    output cbr_pkg::t_vec o_vec
);

    cbr_pkg::t_nstate r_st;
    cbr_pkg::t_vec    r_in;
    cbr_pkg::t_vec    r_out;
    logic             r_fi12;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [31:0]      r_s0;
    logic [29:0]      r_m;
    logic [4:0]       r_sh;
    logic [63:0]      r_rad;
    logic [34:0]      r_rem;
    logic [31:0]      r_root;
    logic [1:0]       r_j;
    logic [15:0]      r_num;
    logic [31:0]      r_drem;
    logic [15:0]      r_q;

    function automatic logic [16:0] mag17(input cbr_pkg::t_comp v);
        logic signed [16:0] e;
        e = {v[15], v};
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    function automatic cbr_pkg::t_comp sat4(input cbr_pkg::t_comp v);
        if (v > 16'sd8191)       return 16'sh7FFF;
        else if (v < -16'sd8192) return 16'sh8000;
        else                     return {v[13:0], 2'b00};
    endfunction

    logic [16:0] w_mg;
    logic [16:0] w_m0, w_m1, w_m2, w_max;
    logic        w_tiny;
    logic [34:0] w_rem2, w_trial;
    logic [30:0] w_magw;
    logic [44:0] w_num;
    logic [32:0] w_r2;
    logic        w_qbit;
    logic [15:0] w_qf;

    always_comb begin
        w_mg    = mag17(cbr_pkg::pick(r_in, r_cnt[1:0]));
        w_m0    = mag17(r_in[0]);
        w_m1    = mag17(r_in[1]);
        w_m2    = mag17(r_in[2]);
        w_max   = (w_m0 > w_m1) ? w_m0 : w_m1;
        w_max   = (w_m2 > w_max) ? w_m2 : w_max;
        w_tiny  = r_fi12 ? (r_s0 <= cbr_pkg::TINY_Q12) : (r_s0 <= cbr_pkg::TINY_Q14);
        w_rem2  = {r_rem[32:0], r_rad[63:62]};
        w_trial = {1'b0, r_root, 2'b01};
        w_magw  = 31'(mag17(cbr_pkg::pick(r_in, r_j))) << r_sh;
        // rounding term len/2 folded into the dividend
        w_num   = {w_magw, 14'd0} + {14'd0, r_root[31:1]};
        w_r2    = {r_drem, r_num[15]};
        w_qbit  = (w_r2 >= {1'b0, r_root});
        w_qf    = {r_q[14:0], w_qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= cbr_pkg::NS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                cbr_pkg::NS_IDLE: begin
                    if (i_start) begin
                        r_in   <= i_vec;
                        r_fi12 <= i_fi12;
                        r_s0   <= '0;
                        r_cnt  <= '0;
                        r_st   <= cbr_pkg::NS_SQ;
                    end
                end
                cbr_pkg::NS_SQ: begin
                    r_s0 <= r_s0 + 32'(w_mg * w_mg);
                    if (r_cnt == 5'd2) begin
                        r_st <= cbr_pkg::NS_CHK;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                cbr_pkg::NS_CHK: begin
                    if (w_tiny) begin
                        // near-zero vector passes through unnormalized, rescaled only for fi12 input
                        for (int i = 0; i < 3; i++) begin
                            r_out[i] <= r_fi12 ? sat4(r_in[i]) : r_in[i];
                        end
                        r_done <= 1'b1;
                        r_st   <= cbr_pkg::NS_IDLE;
                    end else begin
                        r_m  <= {13'd0, w_max};
                        r_sh <= '0;
                        r_st <= cbr_pkg::NS_SHIFT;
                    end
                end
                cbr_pkg::NS_SHIFT: begin
                    if (!r_m[29]) begin
                        r_m  <= {r_m[28:0], 1'b0};
                        r_sh <= r_sh + 5'd1;
                    end else begin
                        r_rad  <= {32'd0, r_s0} << {r_sh, 1'b0};
                        r_rem  <= '0;
                        r_root <= '0;
                        r_cnt  <= 5'd31;
                        r_st   <= cbr_pkg::NS_SQRT;
                    end
                end
                cbr_pkg::NS_SQRT: begin
                    if (w_rem2 >= w_trial) begin
                        r_rem  <= w_rem2 - w_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem2;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_rad <= {r_rad[61:0], 2'b00};
                    if (r_cnt == 5'd0) begin
                        r_j  <= '0;
                        r_st <= cbr_pkg::NS_DLD;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                cbr_pkg::NS_DLD: begin
                    // upper dividend bits are already below len
                    r_drem <= {3'd0, w_num[44:16]};
                    r_num  <= w_num[15:0];
                    r_q    <= '0;
                    r_cnt  <= 5'd15;
                    r_st   <= cbr_pkg::NS_DIV;
                end
                cbr_pkg::NS_DIV: begin
                    r_drem <= w_qbit ? 32'(w_r2 - {1'b0, r_root}) : w_r2[31:0];
                    r_q    <= w_qf;
                    r_num  <= {r_num[14:0], 1'b0};
                    if (r_cnt == 5'd0) begin
                        r_out[r_j] <= r_in[r_j][15] ? 16'(16'd0 - w_qf) : w_qf;
                        if (r_j == 2'd2) begin
                            r_done <= 1'b1;
                            r_st   <= cbr_pkg::NS_IDLE;
                        end else begin
                            r_j  <= r_j + 2'd1;
                            r_st <= cbr_pkg::NS_DLD;
                        end
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                default: r_st <= cbr_pkg::NS_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_vec  = r_out;

endmodule

/* rtl/cbr_datapath.sv */
`timescale 1ns / 1ps
module cbr_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cbr_pkg::t_cmd  i_cmd,
    input  cbr_pkg::t_vec  i_vec,
    input  cbr_pkg::t_comp i_angle,
    output cbr_pkg::t_sts  o_sts,
    output cbr_pkg::t_vec  o_fwd,
    output cbr_pkg::t_vec  o_up,
    output cbr_pkg::t_vec  o_rgt
);

    cbr_pkg::t_vec  r_f, r_u, r_r, r_t, r_x;
    cbr_pkg::t_vec  r_of, r_ou, r_or;
    cbr_pkg::t_comp r_ang, r_c, r_s;
    cbr_pkg::t_vsel r_ndst;

    // normalize unit
    cbr_pkg::t_vec w_nsrc, w_nout;
    logic          w_ndone;

    always_comb begin
        case (i_cmd.uop.src)
            cbr_pkg::V_F: w_nsrc = r_f;
            cbr_pkg::V_T: w_nsrc = r_t;
            default:      w_nsrc = r_x;
        endcase
    end

    cbr_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.norm_start),
        .i_fi12  (i_cmd.uop.fi12),
        .i_vec   (w_nsrc),
        .o_done  (w_ndone),
        .o_vec   (w_nout)
    );

    // product/sum unit: two rounded products per component, one multiplier
    logic                r_mbusy;
    logic [2:0]          r_mcnt;
    cbr_pkg::t_mix       r_mmode;
    logic signed [17:0]  r_acc;
    logic [1:0]          w_j, w_j1, w_j2;
    cbr_pkg::t_comp      w_mx, w_my;
    logic                w_msub;
    logic signed [31:0]  w_prod;
    logic signed [17:0]  w_mf;
    cbr_pkg::t_comp      w_mres;
    logic                w_to_x;

    always_comb begin
        w_j    = r_mcnt[2:1];
        w_j1   = (w_j == 2'd2) ? 2'd0 : 2'(w_j + 2'd1);
        w_j2   = (w_j == 2'd0) ? 2'd2 : 2'(w_j - 2'd1);
        w_mx   = '0;
        w_my   = '0;
        w_msub = 1'b1;
        case (r_mmode)
            cbr_pkg::M_CROSS_FU: begin
                w_mx = r_mcnt[0] ? cbr_pkg::pick(r_f, w_j2) : cbr_pkg::pick(r_f, w_j1);
                w_my = r_mcnt[0] ? cbr_pkg::pick(r_u, w_j1) : cbr_pkg::pick(r_u, w_j2);
            end
            cbr_pkg::M_CROSS_RF: begin
                w_mx = r_mcnt[0] ? cbr_pkg::pick(r_r, w_j2) : cbr_pkg::pick(r_r, w_j1);
                w_my = r_mcnt[0] ? cbr_pkg::pick(r_f, w_j1) : cbr_pkg::pick(r_f, w_j2);
            end
            cbr_pkg::M_YAW: begin
                w_mx = r_mcnt[0] ? cbr_pkg::pick(r_r, w_j) : cbr_pkg::pick(r_f, w_j);
                w_my = r_mcnt[0] ? r_s : r_c;
            end
            cbr_pkg::M_PITCH_F: begin
                w_mx = r_mcnt[0] ? cbr_pkg::pick(r_u, w_j) : cbr_pkg::pick(r_f, w_j);
                w_my = r_mcnt[0] ? r_s : r_c;
            end
            cbr_pkg::M_PITCH_U: begin
                w_mx   = r_mcnt[0] ? cbr_pkg::pick(r_u, w_j) : cbr_pkg::pick(r_f, w_j);
                w_my   = r_mcnt[0] ? r_c : r_s;
                w_msub = 1'b0;
            end
            cbr_pkg::M_ROLL: begin
                w_mx = r_mcnt[0] ? cbr_pkg::pick(r_r, w_j) : cbr_pkg::pick(r_u, w_j);
                w_my = r_mcnt[0] ? r_s : r_c;
            end
            default: ;
        endcase
        w_prod = w_mx * w_my + 32'sd8192;
        w_mf   = w_prod[31:14];
        w_mres = cbr_pkg::sat_comp(w_msub ? 19'(r_acc) - 19'(w_mf) : 19'(r_acc) + 19'(w_mf));
        w_to_x = (r_mmode == cbr_pkg::M_PITCH_U) || (r_mmode == cbr_pkg::M_ROLL);
    end

    // CORDIC
    logic                r_cbusy, r_cfin, r_cneg;
    logic [4:0]          r_ci;
    logic signed [33:0]  r_cx, r_cy;
    logic signed [34:0]  r_cz;
    logic signed [34:0]  w_z0, w_atan;
    logic signed [33:0]  w_dx, w_dy, w_xn, w_yn, w_xr, w_yr;

    always_comb begin
        w_z0   = {{2{r_ang[15]}}, r_ang, 17'd0};
        w_atan = $signed({5'd0, cbr_pkg::atan_q30(r_ci)});
        w_dx   = r_cy >>> r_ci;
        w_dy   = r_cx >>> r_ci;
        w_xn   = r_cneg ? -r_cx : r_cx;
        w_yn   = r_cneg ? -r_cy : r_cy;
        w_xr   = w_xn + 34'sd32768;
        w_yr   = w_yn + 34'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_cbusy <= 1'b0;
            r_cfin  <= 1'b0;
        end else begin
            r_cfin <= 1'b0;
            if (i_cmd.mix_start) begin
                r_mbusy <= 1'b1;
            end else if (r_mbusy && r_mcnt == 3'd5) begin
                r_mbusy <= 1'b0;
            end
            if (i_cmd.cordic_start) begin
                r_cbusy <= 1'b1;
            end else if (r_cbusy && r_ci == 5'(cbr_pkg::CORDIC_STEPS - 1)) begin
                r_cbusy <= 1'b0;
                r_cfin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f <= '{16'sd0, cbr_pkg::ONE_Q14, 16'sd0};
            r_u <= '{16'sd0, 16'sd0, cbr_pkg::ONE_Q14};
            r_r <= '{cbr_pkg::ONE_Q14, 16'sd0, 16'sd0};
        end else begin
            if (w_ndone) begin
                case (r_ndst)
                    cbr_pkg::V_F: r_f <= w_nout;
                    cbr_pkg::V_U: r_u <= w_nout;
                    cbr_pkg::V_R: r_r <= w_nout;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x   <= i_vec;
            r_ang <= i_angle;
        end
        if (i_cmd.norm_start) begin
            r_ndst <= i_cmd.uop.dst;
        end
        if (i_cmd.mix_start) begin
            r_mcnt  <= '0;
            r_mmode <= i_cmd.uop.mix;
        end else if (r_mbusy) begin
            r_mcnt <= r_mcnt + 3'd1;
            if (!r_mcnt[0]) begin
                r_acc <= w_mf;
            end else if (w_to_x) begin
                r_x[w_j] <= w_mres;
            end else begin
                r_t[w_j] <= w_mres;
            end
        end
        if (i_cmd.cordic_start) begin
            // fold angles beyond +-pi/2 back and flip both outputs
            r_ci <= '0;
            r_cx <= cbr_pkg::GAIN_Q30;
            r_cy <= '0;
            if (w_z0 > cbr_pkg::HALF_PI_Q30) begin
                r_cz   <= w_z0 - cbr_pkg::PI_Q30;
                r_cneg <= 1'b1;
            end else if (w_z0 < -cbr_pkg::HALF_PI_Q30) begin
                r_cz   <= w_z0 + cbr_pkg::PI_Q30;
                r_cneg <= 1'b1;
            end else begin
                r_cz   <= w_z0;
                r_cneg <= 1'b0;
            end
        end else if (r_cbusy) begin
            r_ci <= r_ci + 5'd1;
            if (!r_cz[34]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_atan;
            end
        end
        if (r_cfin) begin
            r_c <= w_xr[31:16];
            r_s <= w_yr[31:16];
        end
        if (i_cmd.out_load) begin
            r_of <= r_f;
            r_ou <= r_u;
            r_or <= r_r;
        end
    end

    always_comb begin
        o_sts.norm_done   = w_ndone;
        o_sts.mix_done    = r_mbusy && (r_mcnt == 3'd5);
        o_sts.cordic_done = r_cfin;
    end

    assign o_fwd = r_of;
    assign o_up  = r_ou;
    assign o_rgt = r_or;

endmodule

/* rtl/cbr_ctrl.sv */
`timescale 1ns / 1ps
module cbr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [2:0]    i_op,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  cbr_pkg::t_sts i_sts,
    output cbr_pkg::t_cmd o_cmd
);

    cbr_pkg::t_cstate r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [2:0]       r_step, n_step;
    logic             r_out_valid, n_out_valid;
    cbr_pkg::t_uop    w_uop;

    assign w_uop = cbr_pkg::uop_at(r_op, r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbr_pkg::CS_IDLE;
            r_op        <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.uop   = w_uop;
        case (r_state)
            cbr_pkg::CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_op          = i_op;
                    n_step        = '0;
                    n_state       = cbr_pkg::CS_ISSUE;
                end
            end
            cbr_pkg::CS_ISSUE: begin
                case (w_uop.kind)
                    cbr_pkg::K_NORM: begin
                        o_cmd.norm_start = 1'b1;
                        n_state          = cbr_pkg::CS_WAIT;
                    end
                    cbr_pkg::K_MIX: begin
                        o_cmd.mix_start = 1'b1;
                        n_state         = cbr_pkg::CS_WAIT;
                    end
                    cbr_pkg::K_CORDIC: begin
                        o_cmd.cordic_start = 1'b1;
                        n_state            = cbr_pkg::CS_WAIT;
                    end
                    default: n_state = cbr_pkg::CS_OUT;
                endcase
            end
            cbr_pkg::CS_WAIT: begin
                if (i_sts.norm_done || i_sts.mix_done || i_sts.cordic_done) begin
                    n_step  = r_step + 3'd1;
                    n_state = cbr_pkg::CS_ISSUE;
                end
            end
            cbr_pkg::CS_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = cbr_pkg::CS_IDLE;
                end
            end
            default: n_state = cbr_pkg::CS_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/cbr_checker.sv */
`timescale 1ns / 1ps
module cbr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [63:0]  i_s_axis_tdata,
    input logic [2:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [143:0] o_m_axis_tdata
);

    // nothing pending out of reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // one beat at a time: an accepted beat closes the input until its work ends
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input reopened right after accept");

    // a result never appears the cycle after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !$rose(o_m_axis_tvalid))
        else $error("result raised too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output changed");

endmodule

bind camera_basis_rotator cbr_checker u_chk (.*);
